// ===== hdl/cmeb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmeb_pkg
// Shared types and constants for the coded-mask event back-projection block.
// ----------------------------------------------------------------------------
package cmeb_pkg;

  localparam int MaskLen  = 2048;
  localparam int AddrW    = $clog2(MaskLen);
  localparam int CntW     = AddrW + 1;
  localparam int PosW     = 12;
  localparam int ValW     = 16;
  localparam int NumCells = 4;
  localparam int CellSel  = $clog2(NumCells);

  localparam logic [1:0] OpMaskWr = 2'd0;
  localparam logic [1:0] OpEvent  = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpClear  = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StSkipped = 2'd1;
  localparam logic [1:0] StBadIdx  = 2'd2;

  localparam logic CfgMin = 1'b0;
  localparam logic CfgMax = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_READ,
    S_CLEAR,
    S_OUT
  } state_e;

  // token travelling down the cell row
  typedef struct packed {
    logic             vld;
    logic             clr;
    logic [AddrW-1:0] bin;
    logic             open;
  } tok_t;

  function automatic logic signed [ValW-1:0] sat_upd(
    input logic signed [ValW-1:0] v, input logic open);
    logic signed [ValW:0] s;
    s = open ? ({v[ValW-1], v} + (ValW+1)'(4)) : ({v[ValW-1], v} - (ValW+1)'(1));
    if (s > $signed((ValW+1)'(32767)))       return 16'sh7fff;
    else if (s < -$signed((ValW+1)'(32768))) return 16'sh8000;
    else                                     return s[ValW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cmeb_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmeb_cell
// One image cell: owns the bins whose low address bits match its slot, does a
// read-modify-write on its bank and hands the token to the next cell.
// ----------------------------------------------------------------------------
module cmeb_cell
  import cmeb_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [CellSel-1:0]     slot_i,
  input  wire tok_t                   tok_i,
  output tok_t                        tok_o,
  input  wire logic                   rd_en_i,
  input  wire logic [AddrW-1:0]       rd_addr_i,
  output logic signed [ValW-1:0]      rd_data_o
);

  localparam int BankW = AddrW - CellSel;

  logic signed [ValW-1:0] bank_q [MaskLen/NumCells];
  logic signed [ValW-1:0] rdat_q;
  tok_t                   tok_q;
  logic                   mine;
  logic [BankW-1:0]       waddr;
  logic [BankW-1:0]       raddr;

  // stage 1 reads, stage 2 writes; the bins of one cell are NumCells apart
  assign mine  = tok_i.vld && (tok_i.bin[CellSel-1:0] == slot_i);
  assign waddr = tok_q.bin[AddrW-1:CellSel];
  assign raddr = rd_en_i ? rd_addr_i[AddrW-1:CellSel] : tok_i.bin[AddrW-1:CellSel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= '{vld: mine, clr: tok_i.clr, bin: tok_i.bin, open: tok_i.open};
    end
  end

  always_ff @(posedge clk_i) begin
    rdat_q <= bank_q[raddr];
    if (tok_q.vld) begin
      bank_q[waddr] <= tok_q.clr ? '0 : sat_upd(rdat_q, tok_q.open);
    end
  end

  assign rd_data_o = rdat_q;

  always_comb begin
    tok_o     = tok_i;
    tok_o.vld = tok_i.vld && !mine;
  end

endmodule
`default_nettype wire

// ===== hdl/coded_mask_event_backprojection.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coded_mask_event_backprojection
// Event-driven 1D coded-aperture back-projection into a saturating image.
// ----------------------------------------------------------------------------
// channel  dir  fields (lsb first)
// s_axis   in   tdata: op[1:0] index[12:2] mask_bit[13] event_position[25:14]
// m_axis   out  tdata: status[1:0] image_value[17:2]
// cfg      in   wr_en_i, wr_idx_i (0 event_min, 1 event_max), wr_data_i
// An event issues its L image bins down the cell row, one bin per cycle.
// After reset a clearing pass holds tready low.
// Output word holds until taken; input stalls while busy.
// ----------------------------------------------------------------------------
module coded_mask_event_backprojection
  import cmeb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // op, index, mask_bit, event_position
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // status, image_value
  input  wire logic        wr_en_i,
  input  wire logic        wr_idx_i,
  input  wire logic [11:0] wr_data_i
);

  localparam int Lat = NumCells + 2;

  state_e           state_q, state_d;
  logic [PosW-1:0]  min_q, max_q;
  logic             mask_q [MaskLen];
  logic             mbit_q;
  logic [CntW-1:0]  cnt_q, cnt_d, len;
  logic [AddrW-1:0] off_q, madr;
  logic [3:0]       wait_q, wait_d;
  logic [1:0]       st_q, st_d;
  logic signed [ValW-1:0] val_q;
  logic [AddrW-1:0] ridx_q;
  logic             sweep_tok_q, clr_q;
  logic             boot_q;
  logic [AddrW-1:0] tbin_q;
  tok_t             chain [NumCells+1];
  logic signed [ValW-1:0] rd [NumCells];
  logic             acc;
  logic [1:0]       op;
  logic [AddrW-1:0] idx;
  logic [PosW-1:0]  pos;
  logic [PosW:0]    span;
  logic             rd_en;

  assign op  = s_axis_tdata[1:0];
  assign idx = s_axis_tdata[12:2];
  assign pos = s_axis_tdata[25:14];
  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign span = {1'b0, max_q} - {1'b0, min_q} + (PosW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= 12'd1023;
    end else if (wr_en_i) begin
      if (wr_idx_i == CfgMin) min_q <= wr_data_i;
      else                    max_q <= wr_data_i;
    end
  end

  always_comb begin
    if (max_q < min_q || span >= (PosW+1)'(MaskLen)) len = '0;
    else len = CntW'((PosW+1)'(MaskLen) - span);
  end

  // mask memory, read one address per cycle during a sweep
  assign madr = AddrW'(cnt_q) + off_q;
  always_ff @(posedge clk_i) begin
    if (acc && op == OpMaskWr) mask_q[idx] <= s_axis_tdata[13];
    mbit_q <= mask_q[madr];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    wait_d  = wait_q;
    st_d    = st_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          cnt_d = '0;
          st_d  = StOk;
          case (op)
            OpMaskWr: state_d = S_OUT;
            OpEvent: begin
              if (pos < min_q || pos > max_q) begin
                st_d = StSkipped; state_d = S_OUT;
              end else state_d = S_SWEEP;
            end
            OpRead: begin
              if ({1'b0, idx} >= len) begin
                st_d = StBadIdx; state_d = S_OUT;
              end else state_d = S_READ;
            end
            default: state_d = S_CLEAR;
          endcase
        end
      end
      S_SWEEP: begin
        if (cnt_q >= len) begin
          state_d = S_DRAIN; wait_d = 4'(Lat);
        end else cnt_d = cnt_q + CntW'(1);
      end
      S_CLEAR: begin
        if (cnt_q == CntW'(MaskLen - 1)) begin
          state_d = S_DRAIN; wait_d = 4'(Lat);
        end else cnt_d = cnt_q + CntW'(1);
      end
      S_DRAIN: begin
        if (wait_q == '0) state_d = boot_q ? S_IDLE : S_OUT;
        else wait_d = wait_q - 4'd1;
      end
      S_READ: begin
        if (wait_q == 4'd1) state_d = S_OUT;
        else wait_d = wait_q + 4'd1;
      end
      S_OUT: if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_IDLE) wait_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      wait_q  <= '0;
      st_q    <= StOk;
      sweep_tok_q <= 1'b0;
      clr_q   <= 1'b0;
      boot_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wait_q  <= wait_d;
      st_q    <= st_d;
      sweep_tok_q <= (state_q == S_SWEEP && cnt_q < len) || state_q == S_CLEAR;
      clr_q   <= (state_q == S_CLEAR);
      boot_q  <= boot_q && !(state_q == S_DRAIN && wait_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      off_q  <= AddrW'(pos - min_q);
      ridx_q <= idx;
    end
    tbin_q <= AddrW'(cnt_q);
    if (state_q == S_READ && wait_q == 4'd1) val_q <= rd[ridx_q[CellSel-1:0]];
    else if (state_q == S_IDLE) val_q <= '0;
  end

  assign rd_en = (state_q == S_READ);
  assign chain[0] = '{vld: sweep_tok_q, clr: clr_q, bin: tbin_q, open: mbit_q};

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    cmeb_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .slot_i    (CellSel'(g)),
      .tok_i     (chain[g]),
      .tok_o     (chain[g+1]),
      .rd_en_i   (rd_en),
      .rd_addr_i (ridx_q),
      .rd_data_o (rd[g])
    );
  end

  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, (st_q == StOk) ? val_q : 16'sd0, st_q};

endmodule
`default_nettype wire
